// File: sv/rmpd_pkg.sv
// Shared types, constants and helper functions of the ramped motor PWM driver.
package rmpd_pkg;

	// Width of the period and ramp counters; only these low bits of the registers count.
	localparam int COUNT_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 32;

	// Percent scale and speed limit.
	localparam int PCT_SCALE = 100;
	localparam int SPEED_LIMIT = 100;

	// Reciprocal of 100: (x * RECIP_100) >> RECIP_SHIFT equals x / 100 for any 32-bit x.
	localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
	localparam int RECIP_SHIFT = 37;

	// Reset values, masked to the counter width where the hardware keeps fewer bits.
	localparam longint unsigned CNT_MASK = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam longint unsigned PERIOD_RESET_FULL = 80000;
	localparam longint unsigned RAMP_RESET_FULL = 8000000;
	localparam longint unsigned DUTY_RESET_FULL = 60;
	localparam longint unsigned PERIOD_MASKED = PERIOD_RESET_FULL & CNT_MASK;
	localparam longint unsigned HIGH_RAW = (PERIOD_MASKED * DUTY_RESET_FULL) / PCT_SCALE;
	localparam longint unsigned LOW_RAW = PERIOD_MASKED - HIGH_RAW;
	localparam longint unsigned HIGH_RESET_FULL = (HIGH_RAW == 0) ? 1 : HIGH_RAW;
	localparam longint unsigned LOW_RESET_FULL = (LOW_RAW == 0) ? 1 : LOW_RAW;
	localparam longint unsigned QUO_RESET_FULL = PERIOD_MASKED / PCT_SCALE;
	localparam longint unsigned REM_RESET_FULL = PERIOD_MASKED % PCT_SCALE;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic signed [7:0] speed_t;
	typedef logic [6:0] mag_t;
	typedef logic [6:0] rem_t;

	localparam cnt_t PERIOD_RESET = cnt_t'(PERIOD_MASKED);
	localparam cnt_t RAMP_RESET = cnt_t'(RAMP_RESET_FULL & CNT_MASK);
	localparam mag_t DUTY_RESET = mag_t'(DUTY_RESET_FULL);
	localparam cnt_t HIGH_M1_RESET = cnt_t'(HIGH_RESET_FULL - 1);
	localparam cnt_t LOW_M1_RESET = cnt_t'(LOW_RESET_FULL - 1);
	localparam cnt_t QUO_RESET = cnt_t'(QUO_RESET_FULL);
	localparam rem_t REM_RESET = rem_t'(REM_RESET_FULL);
	localparam speed_t SPEED_MAX = speed_t'(SPEED_LIMIT);
	localparam speed_t SPEED_MIN = speed_t'(-SPEED_LIMIT);

	// Configuration register indexes.
	typedef enum logic {
		REG_PERIOD = 1'b0,
		REG_RAMP   = 1'b1
	} reg_idx_t;

	// Background recalculation sequencer after a period write.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_ACCUM
	} calc_state_t;

	// Phase lengths for one duty value: raw high length, raw low length, and
	// the running remainder of period*duty modulo 100.
	typedef struct packed {
		cnt_t h;
		cnt_t l;
		rem_t rem;
	} cand_t;

	// One result item.
	typedef struct packed {
		logic pin_forward;
		logic pin_reverse;
		speed_t speed_now;
		mag_t speed_magnitude;
		logic forward_dir;
		logic at_target;
	} res_t;

	// Magnitude of a speed that stays within the speed limit.
	function automatic mag_t speed_mag(speed_t s);
		speed_t a;
		a = s[7] ? -s : s;
		return a[6:0];
	endfunction

	// Lengths for duty+1 from the lengths for duty, given period = q*100 + r.
	function automatic cand_t cand_up(cand_t c, cnt_t q, rem_t r);
		logic [7:0] sum;
		logic carry;
		cand_t n;
		sum = {1'b0, c.rem} + {1'b0, r};
		carry = (sum >= 8'(PCT_SCALE));
		n.rem = carry ? rem_t'(sum - 8'(PCT_SCALE)) : sum[6:0];
		n.h = c.h + q + cnt_t'(carry);
		n.l = c.l - q - cnt_t'(carry);
		return n;
	endfunction

	// Lengths for duty-1 from the lengths for duty.
	function automatic cand_t cand_down(cand_t c, cnt_t q, rem_t r);
		logic [7:0] dif;
		logic borrow;
		cand_t n;
		borrow = (c.rem < r);
		dif = borrow ? ({1'b0, c.rem} + 8'(PCT_SCALE) - {1'b0, r}) : ({1'b0, c.rem} - {1'b0, r});
		n.rem = dif[6:0];
		n.h = c.h - q - cnt_t'(borrow);
		n.l = c.l + q + cnt_t'(borrow);
		return n;
	endfunction

	// A length minus one, where a length of zero counts as one.
	function automatic cnt_t len_m1(cnt_t len);
		return (len == '0) ? '0 : (len - cnt_t'(1));
	endfunction

endpackage

// File: sv/rmpd_ifs.sv
// Channel interfaces of the ramped motor PWM driver: command, result and configuration.
interface rmpd_cmd_if;
	logic valid;
	logic ready;
	logic func;
	rmpd_pkg::speed_t target_speed;

	modport source(output valid, output func, output target_speed, input ready);
	modport sink(input valid, input func, input target_speed, output ready);
endinterface

interface rmpd_res_if;
	logic valid;
	logic ready;
	logic pin_forward;
	logic pin_reverse;
	rmpd_pkg::speed_t speed_now;
	rmpd_pkg::mag_t speed_magnitude;
	logic forward_dir;
	logic at_target;

	modport source(output valid, output pin_forward, output pin_reverse, output speed_now,
		output speed_magnitude, output forward_dir, output at_target, input ready);
	modport sink(input valid, input pin_forward, input pin_reverse, input speed_now,
		input speed_magnitude, input forward_dir, input at_target, output ready);
endinterface

interface rmpd_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [rmpd_pkg::CFG_DATA_WIDTH-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/ramped_motor_pwm_driver.sv
// Top level of the ramped motor PWM driver: PWM phase counter, speed ramp and result buffer.
//
// Usage: the cmd channel carries one item per transaction, either a clock tick
// (func = 0) or a new target speed (func = 1, saturated to +/-100). Every item
// produces exactly one result on the res channel with the pin levels, the
// current speed, its magnitude, the direction and the at-target flag after
// that item. The cfg channel writes the period (index 0) and the ramp length
// (index 1); it is always ready.
// The result of an item is registered in the result buffer, and one item is taken
// every cycle while no recalculation runs and the skid register is empty. The
// phase lengths for the duty values one step above and below the current one
// are kept ready in registers, so a ramp step needs only one add in the cycle.
// A period write starts a recalculation of those lengths: a divide by 100 by
// reciprocal multiplication and then one accumulate step per duty unit from
// zero up to the current magnitude plus one; cmd.ready is low throughout.
// Reset puts the block in its power-up state (duty 60, high phase, speed 0).
// When the receiver stalls, a second result is held in a skid register and the
// stall pulls cmd.ready low only when both result registers are full.
module ramped_motor_pwm_driver (
	input logic clk,
	input logic arst_n,
	rmpd_cmd_if.sink cmd,
	rmpd_res_if.source res,
	rmpd_cfg_if.sink cfg
);
	import rmpd_pkg::*;

	// Configuration registers.
	cnt_t period_q;
	cnt_t ramp_q;

	// Motor state.
	speed_t speed_q;
	speed_t target_q;
	mag_t duty_q;
	logic phase_high_q;
	cnt_t phase_cnt_q;
	cnt_t ramp_cnt_q;
	cnt_t hi_m1_q;
	cnt_t lo_m1_q;

	// Phase lengths for magnitude minus one, the magnitude, and plus one.
	cand_t cand_dn_q;
	cand_t cand_md_q;
	cand_t cand_up_q;

	// Period split as quotient and remainder by 100.
	cnt_t quo_q;
	rem_t rem_q;

	// Recalculation sequencer.
	calc_state_t state_q;
	calc_state_t state_n;
	logic busy;
	logic div_run;
	logic acc_run;
	logic div_step_q;
	logic [31:0] div_src;
	logic [63:0] div_prod_q;
	logic [31:0] div_q32;
	logic [31:0] div_back;
	cnt_t div_quo;
	rem_t div_rem;
	logic div_last;
	cand_t acc_q;
	logic [6:0] acc_k_q;
	logic acc_last;
	logic [7:0] cur_mag;

	// Result buffer.
	res_t out_q;
	logic out_v_q;
	res_t skid_q;
	logic skid_v_q;

	// Per-item next-state logic.
	logic accept;
	logic cfg_wr;
	logic period_wr;
	speed_t tgt_sat;
	speed_t target_n;
	logic ph_n;
	cnt_t pc_tick;
	cnt_t rt;
	logic ramp_hit;
	logic step;
	logic spd_inc;
	logic spd_dec;
	logic mag_upw;
	logic mag_dnw;
	speed_t speed_step;
	mag_t mag_step;
	cand_t cand_new;
	cnt_t hi_m1_new;
	cnt_t lo_m1_new;
	logic duty_chg;
	logic ph_f;
	cnt_t pc_f;
	speed_t speed_f;
	res_t res_new;

	assign accept = cmd.valid & cmd.ready;
	assign cfg_wr = cfg.valid & cfg.ready;
	assign period_wr = cfg_wr & (reg_idx_t'(cfg.index) == REG_PERIOD);
	assign cfg.ready = 1'b1;
	assign cmd.ready = ~busy & ~skid_v_q;

	// Sequencer next state; a new period write always restarts the division.
	always_comb begin
		state_n = state_q;
		if (period_wr) begin
			state_n = ST_DIVIDE;
		end else begin
			unique case (state_q)
				ST_IDLE: state_n = ST_IDLE;
				ST_DIVIDE: if (div_last) state_n = ST_ACCUM;
				ST_ACCUM: if (acc_last) state_n = ST_IDLE;
				default: state_n = ST_IDLE;
			endcase
		end
	end

	// Sequencer outputs.
	always_comb begin
		busy = 1'b0;
		div_run = 1'b0;
		acc_run = 1'b0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_DIVIDE: begin
				busy = 1'b1;
				div_run = 1'b1;
			end
			ST_ACCUM: begin
				busy = 1'b1;
				acc_run = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	// Divide by 100: the reciprocal product is registered in div_prod_q,
	// and quotient and remainder are then formed from it.
	assign div_src = 32'(period_q);
	assign div_q32 = 32'(div_prod_q[63:RECIP_SHIFT]);
	assign div_back = (div_q32 << 6) + (div_q32 << 5) + (div_q32 << 2);
	assign div_quo = cnt_t'(div_q32);
	assign div_rem = rem_t'(div_src - div_back);
	assign div_last = div_step_q;

	// Accumulation runs from duty zero up to the current magnitude plus one.
	assign cur_mag = {1'b0, speed_mag(speed_q)};
	assign acc_last = ({1'b0, acc_k_q} == cur_mag + 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_step_q <= 1'b0;
			div_prod_q <= '0;
			acc_q <= '0;
			acc_k_q <= '0;
		end else begin
			state_q <= state_n;
			if (period_wr) begin
				div_step_q <= 1'b0;
			end else if (div_run) begin
				div_step_q <= ~div_step_q;
				if (!div_step_q) begin
					div_prod_q <= {32'd0, div_src} * {32'd0, RECIP_100};
				end
				if (div_last) begin
					acc_q.h <= '0;
					acc_q.l <= period_q;
					acc_q.rem <= '0;
					acc_k_q <= '0;
				end
			end else if (acc_run) begin
				acc_q <= cand_up(acc_q, quo_q, rem_q);
				acc_k_q <= acc_k_q + 7'd1;
			end
		end
	end

	// Target saturation.
	always_comb begin
		priority if (cmd.target_speed > SPEED_MAX) begin
			tgt_sat = SPEED_MAX;
		end else if (cmd.target_speed < SPEED_MIN) begin
			tgt_sat = SPEED_MIN;
		end else begin
			tgt_sat = cmd.target_speed;
		end
	end

	// Phase counter and ramp step for a clock tick.
	always_comb begin
		target_n = cmd.func ? tgt_sat : target_q;
		if (phase_cnt_q == '0) begin
			ph_n = ~phase_high_q;
			pc_tick = ph_n ? hi_m1_q : lo_m1_q;
		end else begin
			ph_n = phase_high_q;
			pc_tick = phase_cnt_q - cnt_t'(1);
		end

		rt = (ramp_q == '0) ? cnt_t'(1) : ramp_q;
		ramp_hit = (({1'b0, ramp_cnt_q} + {{COUNT_WIDTH{1'b0}}, 1'b1}) >= {1'b0, rt});
		step = ~cmd.func & ramp_hit;

		spd_inc = (speed_q < target_q);
		spd_dec = (speed_q > target_q);
		mag_upw = (spd_inc & ~speed_q[7]) | (spd_dec & (speed_q <= 8'sd0));
		mag_dnw = (spd_inc & speed_q[7]) | (spd_dec & (speed_q > 8'sd0));
		priority if (spd_inc) begin
			speed_step = speed_q + 8'sd1;
		end else if (spd_dec) begin
			speed_step = speed_q - 8'sd1;
		end else begin
			speed_step = speed_q;
		end
		mag_step = speed_mag(speed_step);

		priority if (mag_upw) begin
			cand_new = cand_up_q;
		end else if (mag_dnw) begin
			cand_new = cand_dn_q;
		end else begin
			cand_new = cand_md_q;
		end
		hi_m1_new = len_m1(cand_new.h);
		lo_m1_new = len_m1(cand_new.l);
		duty_chg = (mag_step != duty_q);

		// A set-target item leaves the phase and the speed alone.
		ph_f = cmd.func ? phase_high_q : ph_n;
		if (cmd.func) begin
			pc_f = phase_cnt_q;
		end else if (step & duty_chg) begin
			pc_f = ph_n ? hi_m1_new : lo_m1_new;
		end else begin
			pc_f = pc_tick;
		end
		speed_f = step ? speed_step : speed_q;
	end

	// Result of this transaction from the updated state.
	always_comb begin
		res_new.pin_forward = ph_f & ~speed_f[7];
		res_new.pin_reverse = ph_f & speed_f[7];
		res_new.speed_now = speed_f;
		res_new.speed_magnitude = speed_mag(speed_f);
		res_new.forward_dir = ~speed_f[7];
		res_new.at_target = (speed_f == target_n);
	end

	// Configuration registers, quotient and remainder of the period, and motor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			ramp_q <= RAMP_RESET;
			quo_q <= QUO_RESET;
			rem_q <= REM_RESET;
			speed_q <= '0;
			target_q <= '0;
			duty_q <= DUTY_RESET;
			phase_high_q <= 1'b1;
			phase_cnt_q <= HIGH_M1_RESET;
			ramp_cnt_q <= '0;
			hi_m1_q <= HIGH_M1_RESET;
			lo_m1_q <= LOW_M1_RESET;
			cand_dn_q <= '0;
			cand_md_q.h <= '0;
			cand_md_q.l <= PERIOD_RESET;
			cand_md_q.rem <= '0;
			cand_up_q.h <= QUO_RESET;
			cand_up_q.l <= PERIOD_RESET - QUO_RESET;
			cand_up_q.rem <= REM_RESET;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx_t'(cfg.index))
					REG_PERIOD: period_q <= cfg.data[COUNT_WIDTH-1:0];
					REG_RAMP: ramp_q <= cfg.data[COUNT_WIDTH-1:0];
					default: ramp_q <= ramp_q;
				endcase
			end

			// Quotient and remainder are taken when the division ends.
			if (div_run && div_last) begin
				quo_q <= div_quo;
				rem_q <= div_rem;
			end

			// Accumulation drops the lengths for the three neighbor duties in place.
			if (acc_run) begin
				if ({1'b0, acc_k_q} + 8'd1 == cur_mag) cand_dn_q <= acc_q;
				if ({1'b0, acc_k_q} == cur_mag) cand_md_q <= acc_q;
				if (acc_last) cand_up_q <= acc_q;
			end

			if (accept) begin
				target_q <= target_n;
				phase_high_q <= ph_f;
				phase_cnt_q <= pc_f;
				speed_q <= speed_f;
				if (!cmd.func) begin
					ramp_cnt_q <= ramp_hit ? '0 : (ramp_cnt_q + cnt_t'(1));
				end
				if (step) begin
					duty_q <= mag_step;
					hi_m1_q <= hi_m1_new;
					lo_m1_q <= lo_m1_new;
					if (mag_upw) begin
						cand_dn_q <= cand_md_q;
						cand_md_q <= cand_up_q;
						cand_up_q <= cand_up(cand_up_q, quo_q, rem_q);
					end else if (mag_dnw) begin
						cand_up_q <= cand_md_q;
						cand_md_q <= cand_dn_q;
						cand_dn_q <= cand_down(cand_dn_q, quo_q, rem_q);
					end
				end
			end
		end
	end

	// Two-entry result buffer: output register plus skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if ((out_v_q && res.ready) || !out_v_q) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= accept;
				end else begin
					out_v_q <= accept;
				end
			end else if (accept) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((out_v_q && res.ready) || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (accept) skid_q <= res_new;
			end else if (accept) begin
				out_q <= res_new;
			end
		end else if (accept) begin
			skid_q <= res_new;
		end
	end

	assign res.valid = out_v_q;
	assign res.pin_forward = out_q.pin_forward;
	assign res.pin_reverse = out_q.pin_reverse;
	assign res.speed_now = out_q.speed_now;
	assign res.speed_magnitude = out_q.speed_magnitude;
	assign res.forward_dir = out_q.forward_dir;
	assign res.at_target = out_q.at_target;

endmodule

// File: tb/ramped_motor_pwm_driver_tb.sv
// Self-checking testbench of the ramped motor PWM driver with a per-command predictor.
`timescale 1ns / 100ps

module ramped_motor_pwm_driver_tb;
	import rmpd_pkg::*;

	// Command codes on the func field.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;

	logic clk;
	logic arst_n;

	rmpd_cmd_if cmd_ch();
	rmpd_res_if res_ch();
	rmpd_cfg_if cfg_ch();

	ramped_motor_pwm_driver uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// Predicted driver state and register copies.
	logic [31:0] period_q;
	logic [31:0] ramp_q;
	int speed_cur;
	int speed_goal;
	int unsigned duty_pct;
	bit in_high_phase;
	logic [31:0] phase_left;
	logic [31:0] ramp_elapsed;
	logic [31:0] high_len_q;
	logic [31:0] low_len_q;

	// Results predicted but not yet seen on the result channel.
	res_t results_due[$];

	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int idle_cycles = 0;
	int unsigned cyc_count = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_hold = 0;

	// Clock generation.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	// Phase lengths for the current duty and period, each at least one tick.
	function automatic void recalc_lengths();
		logic [63:0] prod;
		logic [31:0] h;
		logic [31:0] l;
		prod = 64'(period_q) * 64'(duty_pct);
		h = 32'(prod / 64'd100);
		l = period_q - h;
		if (h == 32'd0) h = 32'd1;
		if (l == 32'd0) l = 32'd1;
		high_len_q = h;
		low_len_q = l;
	endfunction

	function automatic void reload_phase_count();
		phase_left = (in_high_phase ? high_len_q : low_len_q) - 32'd1;
	endfunction

	function automatic void reset_prediction();
		period_q = 32'd80000;
		ramp_q = 32'd8000000;
		speed_cur = 0;
		speed_goal = 0;
		duty_pct = 60;
		in_high_phase = 1'b1;
		ramp_elapsed = 32'd0;
		recalc_lengths();
		reload_phase_count();
	endfunction

	// One clock tick: PWM phase counter, then the ramp step when due.
	function automatic void advance_tick();
		logic [31:0] ramp_len;
		int unsigned mag;
		if (phase_left == 32'd0) begin
			in_high_phase = ~in_high_phase;
			reload_phase_count();
		end else begin
			phase_left = phase_left - 32'd1;
		end
		ramp_len = (ramp_q == 32'd0) ? 32'd1 : ramp_q;
		if (33'(ramp_elapsed) + 33'd1 >= 33'(ramp_len)) begin
			ramp_elapsed = 32'd0;
			if (speed_cur < speed_goal) speed_cur++;
			else if (speed_cur > speed_goal) speed_cur--;
			mag = (speed_cur < 0) ? -speed_cur : speed_cur;
			if (mag > 100) mag = 100;
			if (mag != duty_pct) begin
				duty_pct = mag;
				recalc_lengths();
				reload_phase_count();
			end else begin
				recalc_lengths();
			end
		end else begin
			ramp_elapsed = ramp_elapsed + 32'd1;
		end
	endfunction

	// Apply one command and return the result it causes.
	function automatic res_t predict_drive(logic f, speed_t t);
		int goal;
		bit fwd;
		int mag;
		res_t r;
		if (f == FUNC_SET) begin
			goal = t;
			if (goal > SPEED_LIMIT) goal = SPEED_LIMIT;
			if (goal < -SPEED_LIMIT) goal = -SPEED_LIMIT;
			speed_goal = goal;
		end else begin
			advance_tick();
		end
		fwd = (speed_cur >= 0);
		mag = fwd ? speed_cur : -speed_cur;
		r.pin_forward = in_high_phase && fwd;
		r.pin_reverse = in_high_phase && !fwd;
		r.speed_now = speed_t'(speed_cur);
		r.speed_magnitude = mag_t'(mag);
		r.forward_dir = fwd;
		r.at_target = (speed_cur == speed_goal);
		return r;
	endfunction

	// Send one command in bursts, with random gaps between them while gaps_on is set.
	task automatic send_cmd(logic f, speed_t t);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= f;
		cmd_ch.target_speed <= t;
		do @(posedge clk); while (!cmd_ch.ready);
		results_due.push_back(predict_drive(f, t));
		items_sent++;
	endtask

	// Stop sending and wait until every predicted result has arrived.
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register write, issued only after all pending results have drained.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		drain_results();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_PERIOD) period_q = value;
		else ramp_q = value;
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_cmd(FUNC_TICK, speed_t'(0));
	endtask

	// Power-up state under the reset register values.
	task automatic test_reset_state();
		send_ticks(3);
	endtask

	// Targets beyond the speed limit are clamped.
	task automatic test_target_saturation();
		send_cmd(FUNC_SET, speed_t'(127));
		send_cmd(FUNC_SET, speed_t'(-128));
		send_cmd(FUNC_SET, speed_t'(101));
	endtask

	// Minimum period, where a computed length of zero is raised to one, and a
	// zero ramp length, which steps on every tick; the last step keeps the duty.
	task automatic test_short_period();
		write_reg(REG_PERIOD, 32'd2);
		write_reg(REG_RAMP, 32'd0);
		send_cmd(FUNC_SET, speed_t'(3));
		send_ticks(4);
	endtask

	// Full-width period while the speed ramps through zero into reverse.
	task automatic test_wide_period();
		write_reg(REG_PERIOD, 32'hFFFF_FFFF);
		write_reg(REG_RAMP, 32'd1);
		send_cmd(FUNC_SET, speed_t'(-2));
		send_ticks(5);
	endtask

	// The ramp length is lowered below the running count; the next tick steps.
	task automatic test_ramp_lowered();
		write_reg(REG_RAMP, 32'hFFFF_FFFF);
		send_cmd(FUNC_SET, speed_t'(4));
		send_ticks(3);
		write_reg(REG_RAMP, 32'd2);
		send_ticks(2);
	endtask

	// A new period is held until the next ramp step.
	task automatic test_period_deferred();
		write_reg(REG_PERIOD, 32'd10);
		send_ticks(3);
	endtask

	// Random traffic over a series of register settings, extremes included.
	task automatic test_random_ramps();
		logic [31:0] per;
		logic [31:0] rmp;
		int pick;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin per = 32'd2; rmp = 32'd1; end
				1: begin per = 32'hFFFF_FFFF; rmp = 32'd0; end
				2: begin per = 32'd3; rmp = 32'd2; end
				3: begin per = $urandom | 32'h8000_0000; rmp = 32'd1; end
				default: begin
					per = $urandom_range(2, 300);
					rmp = $urandom_range(1, 4);
				end
			endcase
			write_reg(REG_PERIOD, per);
			write_reg(REG_RAMP, rmp);
			gaps_on = (ph % 3 != 2);
			repeat (150) begin
				pick = $urandom_range(0, 99);
				if (pick < 88) begin
					send_cmd(FUNC_TICK, speed_t'($urandom_range(0, 255)));
				end else if (pick < 97) begin
					send_cmd(FUNC_SET, speed_t'($urandom_range(0, 200) - 100));
				end else begin
					send_cmd(FUNC_SET, speed_t'($urandom_range(0, 255)));
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	// Result checking against the oldest prediction.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result transaction with no prediction pending");
			end else begin
				want = results_due.pop_front();
				got.pin_forward = res_ch.pin_forward;
				got.pin_reverse = res_ch.pin_reverse;
				got.speed_now = res_ch.speed_now;
				got.speed_magnitude = res_ch.speed_magnitude;
				got.forward_dir = res_ch.forward_dir;
				got.at_target = res_ch.at_target;
				results_checked++;
				if (got.pin_forward !== want.pin_forward)
					report_mismatch($sformatf("pin_forward got %b expected %b",
						got.pin_forward, want.pin_forward));
				if (got.pin_reverse !== want.pin_reverse)
					report_mismatch($sformatf("pin_reverse got %b expected %b",
						got.pin_reverse, want.pin_reverse));
				if (got.speed_now !== want.speed_now)
					report_mismatch($sformatf("speed_now got %0d expected %0d",
						got.speed_now, want.speed_now));
				if (got.speed_magnitude !== want.speed_magnitude)
					report_mismatch($sformatf("speed_magnitude got %0d expected %0d",
						got.speed_magnitude, want.speed_magnitude));
				if (got.forward_dir !== want.forward_dir)
					report_mismatch($sformatf("forward_dir got %b expected %b",
						got.forward_dir, want.forward_dir));
				if (got.at_target !== want.at_target)
					report_mismatch($sformatf("at_target got %b expected %b",
						got.at_target, want.at_target));
			end
		end
	end

	// Watchdog on cycles in which no channel completes a transaction.
	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Receiver back-pressure: modes of always ready, random, periodic and long stalls.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_mode_left <= $urandom_range(40, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 9) < 7);
			2: res_ch.ready <= (cyc_count[2:0] > 3'd2);
			default: res_ch.ready <= (cyc_count[3:0] < 4'd4);
		endcase
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_TICK;
		cmd_ch.target_speed = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PERIOD;
		cfg_ch.data = '0;
		reset_prediction();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_target_saturation();
		test_short_period();
		test_wide_period();
		test_ramp_lowered();
		test_period_deferred();
		test_random_ramps();

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d commands and %0d results over %0d register writes,",
			items_sent, results_checked, reg_writes);
		$display("including clamped targets, minimum and full-width periods and ramp steps.");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
